>>> rtl/core/bmf_pkg.sv
package bmf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_W   = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index codes (byte address bit 2).
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam int NUM_TAPS  = 9;
  localparam int TAP_W     = 4;
  localparam int SUM_W     = 12;
  localparam int CNT_W     = 4;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_W     = 4;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel_value;
  } pix_word_t;

  typedef struct packed {
    logic [7:0] smoothed_value;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       image_done;
  } res_word_t;

  typedef struct packed {
    logic             accept;
    logic             tap_start;
    logic             tap_issue;
    logic [TAP_W-1:0] tap;
    logic             div_step;
    logic             next_job;
  } bmf_cmd_t;

  typedef struct packed {
    logic job_valid;
    logic second_pending;
  } bmf_sts_t;

  function automatic logic [1:0] tap_dr(input logic [TAP_W-1:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_dc(input logic [TAP_W-1:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

>>> rtl/core/bmf_ctrl.sv
module bmf_ctrl
  import bmf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     pix_valid,
  output logic     pix_ready,
  output logic     res_valid,
  input  logic     res_ready,
  input  bmf_sts_t sts,
  output bmf_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_TAP   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state, state_next;
  logic [TAP_W-1:0] tap_cnt, tap_cnt_next;
  logic [DIV_W-1:0] div_cnt, div_cnt_next;

  always_comb begin
    state_next   = state;
    tap_cnt_next = tap_cnt;
    div_cnt_next = div_cnt;
    cmd          = '0;
    cmd.tap      = tap_cnt;
    pix_ready    = 1'b0;
    res_valid    = 1'b0;
    unique case (state)
      S_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid) begin
          cmd.accept = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.job_valid) begin
          cmd.tap_start = 1'b1;
          tap_cnt_next  = '0;
          state_next    = S_TAP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TAP: begin
        // One read is issued per tap; the last cycle only folds in the final read.
        cmd.tap_issue = (tap_cnt < TAP_W'(NUM_TAPS));
        if (tap_cnt == TAP_W'(NUM_TAPS)) begin
          div_cnt_next = '0;
          state_next   = S_DIV;
        end else begin
          tap_cnt_next = tap_cnt + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_W'(DIV_STEPS - 1)) begin
          state_next = S_OUT;
        end else begin
          div_cnt_next = div_cnt + 1'b1;
        end
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (sts.second_pending) begin
            cmd.next_job  = 1'b1;
            cmd.tap_start = 1'b1;
            tap_cnt_next  = '0;
            state_next    = S_TAP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tap_cnt <= '0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      tap_cnt <= tap_cnt_next;
      div_cnt <= div_cnt_next;
    end
  end

endmodule

>>> rtl/core/bmf_datapath.sv
module bmf_datapath
  import bmf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  pix_word_t        pix_data,
  input  logic [CFG_W-1:0] cfg_width,
  input  logic [CFG_W-1:0] cfg_height,
  input  bmf_cmd_t         cmd,
  output bmf_sts_t         sts,
  output res_word_t        res_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(3 * MAX_WIDTH);

  logic [7:0] mem [0:3*MAX_WIDTH-1];

  logic [DW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic [CW-1:0] drain_col;
  logic [1:0]    in_slot;
  logic          draining;

  logic          job_valid;
  logic          second_pending;
  logic [RW-1:0] j_row;
  logic [CW-1:0] j_col;
  logic [1:0]    j_slot;
  logic          j_done;

  logic [SUM_W-1:0] acc;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rem;
  logic [7:0]       rd_data;
  logic             rd_valid;

  logic          end_row, last_row, drain_last;
  logic [1:0]    dr, dc;
  logic          row_ok, col_ok, tap_ok;
  logic [1:0]    t_slot;
  logic [31:0]   cc32;
  logic [AW-1:0] base, rd_addr, wr_addr;
  logic [CNT_W:0] trial;
  logic [31:0]   row32, col32;

  always_comb begin
    if (cfg_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height);
    end
  end

  assign end_row    = (32'(in_col) + 32'd1 >= 32'(w_eff));
  assign last_row   = (32'(in_row) + 32'd1 >= 32'(h_eff));
  assign drain_last = (32'(drain_col) + 32'd1 >= 32'(w_eff));

  function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
    logic [AW-1:0] b;
    case (s)
      2'd0:    b = '0;
      2'd1:    b = AW'(MAX_WIDTH);
      default: b = AW'(2 * MAX_WIDTH);
    endcase
    return b;
  endfunction

  // Tap address and whether the tap lies inside the image.
  always_comb begin
    dr = tap_dr(cmd.tap);
    dc = tap_dc(cmd.tap);
    case (dr)
      2'd0: begin
        row_ok = (j_row != '0) && (32'(j_row) < 32'(h_eff) + 32'd1);
        t_slot = slot_dec(j_slot);
      end
      2'd1: begin
        row_ok = (32'(j_row) < 32'(h_eff));
        t_slot = j_slot;
      end
      default: begin
        row_ok = (32'(j_row) + 32'd1 < 32'(h_eff));
        t_slot = slot_inc(j_slot);
      end
    endcase
    case (dc)
      2'd0:    col_ok = (j_col != '0) && (32'(j_col) < 32'(w_eff) + 32'd1);
      2'd1:    col_ok = (32'(j_col) < 32'(w_eff));
      default: col_ok = (32'(j_col) + 32'd1 < 32'(w_eff));
    endcase
    tap_ok  = row_ok && col_ok;
    cc32    = 32'(j_col) + 32'(dc) - 32'd1;
    base    = slot_base(t_slot);
    rd_addr = base + cc32[AW-1:0];
    wr_addr = slot_base(in_slot) + AW'(in_col);
    trial   = {rem, acc[SUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && pix_data.action == ACT_PIXEL && !draining) begin
      mem[wr_addr] <= pix_data.pixel_value;
    end
    if (cmd.tap_issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row         <= '0;
      in_col         <= '0;
      drain_col      <= '0;
      in_slot        <= '0;
      draining       <= 1'b0;
      job_valid      <= 1'b0;
      second_pending <= 1'b0;
      rd_valid       <= 1'b0;
    end else begin
      rd_valid <= cmd.tap_issue && tap_ok;
      if (cmd.accept) begin
        job_valid      <= 1'b0;
        second_pending <= 1'b0;
        j_done         <= 1'b0;
        if (pix_data.action == ACT_DRAIN) begin
          if (draining) begin
            job_valid <= 1'b1;
            j_row     <= in_row;
            j_col     <= drain_col;
            j_slot    <= in_slot;
            j_done    <= drain_last;
            if (drain_last) begin
              in_row    <= '0;
              in_col    <= '0;
              drain_col <= '0;
              in_slot   <= '0;
              draining  <= 1'b0;
            end else begin
              drain_col <= drain_col + 1'b1;
            end
          end
        end else if (!draining) begin
          // The row above is now complete up to this column.
          j_row  <= in_row - 1'b1;
          j_slot <= slot_dec(in_slot);
          if (in_row != '0) begin
            job_valid      <= (in_col != '0) || end_row;
            second_pending <= (in_col != '0) && end_row;
          end
          j_col <= (in_col != '0) ? in_col - 1'b1 : in_col;
          if (end_row) begin
            in_col <= '0;
            if (last_row) begin
              draining  <= 1'b1;
              drain_col <= '0;
            end else begin
              in_row  <= in_row + 1'b1;
              in_slot <= slot_inc(in_slot);
            end
          end else begin
            in_col <= in_col + 1'b1;
          end
        end
      end
      if (cmd.next_job) begin
        second_pending <= 1'b0;
        j_col          <= j_col + 1'b1;
      end
    end
  end

  // Sum the taps, then divide by shifting the sum through a restoring divider.
  always_ff @(posedge clk) begin
    if (cmd.tap_start) begin
      acc   <= '0;
      count <= '0;
      rem   <= '0;
    end else begin
      if (cmd.tap_issue && tap_ok) begin
        count <= count + 1'b1;
      end
      if (rd_valid) begin
        acc <= acc + SUM_W'(rd_data);
      end
      if (cmd.div_step) begin
        if (trial >= {1'b0, count}) begin
          rem <= CNT_W'(trial - {1'b0, count});
          acc <= {acc[SUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[CNT_W-1:0];
          acc <= {acc[SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign row32 = 32'(j_row);
  assign col32 = 32'(j_col);

  always_comb begin
    res_data.smoothed_value = (count == '0) ? 8'd0 : acc[7:0];
    res_data.out_row        = row32[9:0];
    res_data.out_col        = col32[9:0];
    res_data.image_done     = j_done;
  end

  assign sts.job_valid      = job_valid;
  assign sts.second_pending = second_pending;

endmodule

>>> rtl/core/box_mean_3x3_filter.sv
// 3x3 box-mean filter with border clipping. Program image_width and
// image_height over the APB port (byte addresses 0 and 4; 0 acts as 1,
// values above the maximum act as the maximum), then stream pixels in raster
// order with action 0. Results come out in raster order one row and one
// column behind, each the floor of the mean over the neighbors inside the
// image. After the last pixel, send one drain word (action 1) per pixel of
// the last row; image_done marks the final result and rearms the block for
// the next image. Each word is handled on its own: the block takes no new word
// until every result it yields has been taken. Each result is made by reading
// and adding the nine taps from the line store, then running a bit-serial
// divider, and is then presented until it is taken.
module box_mean_3x3_filter
  import bmf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  output logic               pix_ready,
  input  pix_word_t          pix_data,
  output logic               res_valid,
  input  logic               res_ready,
  output res_word_t          res_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  bmf_cmd_t         cmd;
  bmf_sts_t         sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= CFG_W'(1);
      cfg_height <= CFG_W'(1);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WIDTH:  cfg_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: cfg_height <= pwdata[CFG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = PDATA_W'(cfg_width);
      REG_HEIGHT: prdata = PDATA_W'(cfg_height);
      default:    prdata = '0;
    endcase
  end

  bmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .pix_data   (pix_data),
    .cfg_width  (cfg_width),
    .cfg_height (cfg_height),
    .cmd        (cmd),
    .sts        (sts),
    .res_data   (res_data)
  );

endmodule
